### hdl/bce_pkg.sv
// ----------------------------------------------------------------------------
// bce_pkg
// Shared widths, register indexes, discharge table and divider types for the
// battery charge estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package bce_pkg;

  // Converter and table sizing
  localparam int ADC_BITS     = 12;
  localparam int TABLE_POINTS = 21;
  localparam int TABLE_CAP    = 32;
  localparam int POINTS       = (TABLE_POINTS > TABLE_CAP) ? TABLE_CAP : TABLE_POINTS;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int REF_W    = 13;
  localparam int BIAS_W   = 10;
  localparam int VOLT_W   = 14;
  localparam int PCT_W    = 7;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 1;

  // Internal widths
  localparam int PROD_W  = REF_W + ADC_BITS;      // reference * sample
  localparam int CNT_W   = 6;                     // holds ADC_BITS and TABLE_CAP
  localparam int IDX_W   = 5;                     // table address
  localparam int NUM_W   = VOLT_W + PCT_W;        // interpolation numerator
  localparam int QUO_W   = PCT_W;                 // interpolation quotient
  localparam int QCNT_W  = $clog2(QUO_W + 1);

  localparam logic [VOLT_W-1:0] VOLT_MAX = {VOLT_W{1'b1}};
  localparam logic [PCT_W-1:0]  PCT_MAX  = PCT_W'(100);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BIAS      = CFG_IDX_W'(1);

  localparam logic [REF_W-1:0]  REFERENCE_RST = REF_W'(3300);
  localparam logic [BIAS_W-1:0] BIAS_RST      = BIAS_W'(200);

  // Divider handshake
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [VOLT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

  // LiPo discharge curve, highest voltage first; unused slots read as zero
  function automatic logic [VOLT_W-1:0] tbl_mv(input logic [IDX_W-1:0] idx);
    logic [VOLT_W-1:0] v;
    case (idx)
      5'd0:    v = VOLT_W'(4200);
      5'd1:    v = VOLT_W'(4150);
      5'd2:    v = VOLT_W'(4110);
      5'd3:    v = VOLT_W'(4080);
      5'd4:    v = VOLT_W'(4020);
      5'd5:    v = VOLT_W'(3980);
      5'd6:    v = VOLT_W'(3950);
      5'd7:    v = VOLT_W'(3910);
      5'd8:    v = VOLT_W'(3870);
      5'd9:    v = VOLT_W'(3850);
      5'd10:   v = VOLT_W'(3840);
      5'd11:   v = VOLT_W'(3820);
      5'd12:   v = VOLT_W'(3800);
      5'd13:   v = VOLT_W'(3790);
      5'd14:   v = VOLT_W'(3770);
      5'd15:   v = VOLT_W'(3750);
      5'd16:   v = VOLT_W'(3730);
      5'd17:   v = VOLT_W'(3710);
      5'd18:   v = VOLT_W'(3690);
      5'd19:   v = VOLT_W'(3610);
      5'd20:   v = VOLT_W'(3270);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] tbl_pct(input logic [IDX_W-1:0] idx);
    logic [PCT_W-1:0] p;
    case (idx)
      5'd0:    p = PCT_W'(100);
      5'd1:    p = PCT_W'(95);
      5'd2:    p = PCT_W'(90);
      5'd3:    p = PCT_W'(85);
      5'd4:    p = PCT_W'(80);
      5'd5:    p = PCT_W'(75);
      5'd6:    p = PCT_W'(70);
      5'd7:    p = PCT_W'(65);
      5'd8:    p = PCT_W'(60);
      5'd9:    p = PCT_W'(55);
      5'd10:   p = PCT_W'(50);
      5'd11:   p = PCT_W'(45);
      5'd12:   p = PCT_W'(40);
      5'd13:   p = PCT_W'(35);
      5'd14:   p = PCT_W'(30);
      5'd15:   p = PCT_W'(25);
      5'd16:   p = PCT_W'(20);
      5'd17:   p = PCT_W'(15);
      5'd18:   p = PCT_W'(10);
      5'd19:   p = PCT_W'(5);
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

### hdl/bce_in_if.sv
// ----------------------------------------------------------------------------
// bce_in_if
// Sample channel: valid/ready handshake carrying one converter reading.
// ----------------------------------------------------------------------------
`default_nettype none

interface bce_in_if;
  import bce_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

### hdl/bce_out_if.sv
// ----------------------------------------------------------------------------
// bce_out_if
// Result channel: valid/ready handshake carrying voltage and charge figures.
// ----------------------------------------------------------------------------
`default_nettype none

interface bce_out_if;
  import bce_pkg::*;

  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] sample_voltage_mv;
  logic [PCT_W-1:0]  sample_percent;
  logic [VOLT_W-1:0] smoothed_voltage_mv;
  logic [PCT_W-1:0]  smoothed_percent;

  modport source (output valid, output sample_voltage_mv, output sample_percent,
                  output smoothed_voltage_mv, output smoothed_percent, input ready);
  modport sink   (input valid, input sample_voltage_mv, input sample_percent,
                  input smoothed_voltage_mv, input smoothed_percent, output ready);
endinterface

`default_nettype wire

### hdl/bce_divider.sv
// ----------------------------------------------------------------------------
// bce_divider
// Restoring divider, one quotient bit per cycle, for segment interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module bce_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bce_pkg::div_req_t req_i,
  output bce_pkg::div_rsp_t      rsp_o
);
  import bce_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  dsh_q, dsh_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic              fits;

  assign fits = (rem_q >= dsh_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = QCNT_W'(QUO_W);
      rem_d  = req_i.num;
      dsh_d  = NUM_W'(req_i.den) << (QUO_W - 1);
      quo_d  = '0;
    end else if (busy_q) begin
      // subtract when the shifted divisor fits, then move one bit down
      if (fits) begin
        rem_d = rem_q - dsh_q;
      end
      quo_d = {quo_q[QUO_W-2:0], fits};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - QCNT_W'(1);
      if (cnt_q == QCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

`default_nettype wire

### hdl/battery_charge_estimator.sv
// ----------------------------------------------------------------------------
// battery_charge_estimator
// Converts a battery divider reading to millivolts, maps it to a LiPo charge
// percentage by piecewise-linear lookup, and keeps half-weight running means.
// ----------------------------------------------------------------------------
// Sequence: a sample beat starts the 12-step shift-add multiply, followed by
//   the table walk at one point per cycle (up to 22 steps) and, inside a
//   segment, the 7-step serial divider; then the result is registered.
// Samples: one at a time, each finished before the next; the next sample is taken as
//   soon as the sequencer is back in idle, even while the last result waits.
// Reset: asynchronous, active low; registers return to 3300 mV and 200 mV,
//   the running means clear and the first sample after reset loads them.
`default_nettype none

module battery_charge_estimator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [bce_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bce_pkg::CFG_W-1:0]  cfg_data_i,
  bce_in_if.sink                          sample_i,
  bce_out_if.source                       result_o
);
  import bce_pkg::*;

  // Sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_VOLT   = 3'd2;
  localparam logic [2:0] ST_SEARCH = 3'd3;
  localparam logic [2:0] ST_INTERP = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  // Configuration registers
  logic [REF_W-1:0]  ref_q;
  logic [BIAS_W-1:0] bias_q;

  // Sequencer and datapath
  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [ADC_BITS-1:0] samp_q, samp_d;     // multiplier bits, LSB first
  logic [PROD_W-1:0]   mcand_q, mcand_d;   // reference, shifted up each step
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [VOLT_W-1:0]   mv_q, mv_d;
  logic [PCT_W-1:0]    pct_q, pct_d;
  logic [PCT_W-1:0]    base_q, base_d;     // lower point's percentage

  // Running means and result register
  logic              primed_q, primed_d;
  logic [VOLT_W-1:0] avg_v_q, avg_v_d;
  logic [PCT_W-1:0]  avg_p_q, avg_p_d;
  logic              ovalid_q, ovalid_d;
  logic [VOLT_W-1:0] out_v_q, out_v_d;
  logic [PCT_W-1:0]  out_p_q, out_p_d;

  // Combinational helpers
  logic [IDX_W-1:0]  idx_lo, idx_hi;
  logic [VOLT_W-1:0] lo_mv, hi_mv, span, diff;
  logic [PCT_W-1:0]  lo_pct, hi_pct, pdiff;
  logic [VOLT_W:0]   volt_sum;
  logic [PCT_W:0]    pct_sum;
  logic [VOLT_W:0]   avg_v_sum;
  logic [PCT_W:0]    avg_p_sum;
  logic              sample_beat, result_beat, flat_seg;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign sample_beat = sample_i.valid && sample_i.ready;
  assign result_beat = result_o.valid && result_o.ready;
  assign sample_i.ready = (state_q == ST_IDLE);

  // Segment endpoints: the counter stops on the first point below the voltage
  assign idx_lo  = cnt_q[IDX_W-1:0];
  assign idx_hi  = idx_lo - IDX_W'(1);
  assign lo_mv   = tbl_mv(idx_lo);
  assign hi_mv   = tbl_mv(idx_hi);
  assign lo_pct  = tbl_pct(idx_lo);
  assign hi_pct  = tbl_pct(idx_hi);
  assign span    = hi_mv - lo_mv;
  assign diff    = mv_q - lo_mv;
  assign pdiff   = hi_pct - lo_pct;
  assign flat_seg = (span == '0) || (hi_mv < lo_mv) || (hi_pct < lo_pct);

  // Scale the product by 2 / 2^ADC_BITS and add the bias
  assign volt_sum = {1'b0, prod_q[PROD_W-1:ADC_BITS-1]} + (VOLT_W+1)'(bias_q);
  assign pct_sum  = {1'b0, base_q} + {1'b0, div_rsp.quot};

  assign avg_v_sum = {1'b0, avg_v_q} + {1'b0, mv_q};
  assign avg_p_sum = {1'b0, avg_p_q} + {1'b0, pct_q};

  always_comb begin
    div_req.start = (state_q == ST_INTERP) && !flat_seg;
    div_req.num   = NUM_W'(diff) * NUM_W'(pdiff);
    div_req.den   = span;
  end

  bce_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    samp_d   = samp_q;
    mcand_d  = mcand_q;
    prod_d   = prod_q;
    mv_d     = mv_q;
    pct_d    = pct_q;
    base_d   = base_q;
    primed_d = primed_q;
    avg_v_d  = avg_v_q;
    avg_p_d  = avg_p_q;
    ovalid_d = ovalid_q && !result_beat;
    out_v_d  = out_v_q;
    out_p_d  = out_p_q;

    case (state_q)
      ST_IDLE: begin
        if (sample_beat) begin
          samp_d  = sample_i.adc_sample[ADC_BITS-1:0];
          mcand_d = PROD_W'(ref_q);
          prod_d  = '0;
          cnt_d   = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        // add one partial product per sample bit
        if (samp_q[0]) begin
          prod_d = prod_q + mcand_q;
        end
        samp_d  = samp_q >> 1;
        mcand_d = mcand_q << 1;
        cnt_d   = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ADC_BITS - 1)) begin
          state_d = ST_VOLT;
        end
      end
      ST_VOLT: begin
        mv_d    = volt_sum[VOLT_W] ? VOLT_MAX : volt_sum[VOLT_W-1:0];
        cnt_d   = '0;
        state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        // walk the curve from the top until the voltage exceeds a point
        if (cnt_q == CNT_W'(POINTS)) begin
          pct_d   = '0;
          state_d = ST_DONE;
        end else if (mv_q > lo_mv) begin
          if (cnt_q == '0) begin
            pct_d   = PCT_MAX;
            state_d = ST_DONE;
          end else begin
            state_d = ST_INTERP;
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_INTERP: begin
        base_d = lo_pct;
        if (flat_seg) begin
          pct_d   = lo_pct;
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          pct_d   = (pct_sum > {1'b0, PCT_MAX}) ? PCT_MAX : pct_sum[PCT_W-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the result register is free, then update the means
        if (!ovalid_q || result_o.ready) begin
          if (primed_q) begin
            avg_v_d = avg_v_sum[VOLT_W:1];
            avg_p_d = avg_p_sum[PCT_W:1];
          end else begin
            avg_v_d = mv_q;
            avg_p_d = pct_q;
          end
          primed_d = 1'b1;
          out_v_d  = mv_q;
          out_p_d  = pct_q;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q    <= REFERENCE_RST;
      bias_q   <= BIAS_RST;
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      primed_q <= 1'b0;
      avg_v_q  <= '0;
      avg_p_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_REFERENCE: ref_q  <= cfg_data_i[REF_W-1:0];
          REG_BIAS:      bias_q <= cfg_data_i[BIAS_W-1:0];
          default: begin
          end
        endcase
      end
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      primed_q <= primed_d;
      avg_v_q  <= avg_v_d;
      avg_p_q  <= avg_p_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q  <= samp_d;
    mcand_q <= mcand_d;
    prod_q  <= prod_d;
    mv_q    <= mv_d;
    pct_q   <= pct_d;
    base_q  <= base_d;
    out_v_q <= out_v_d;
    out_p_q <= out_p_d;
  end

  assign result_o.valid               = ovalid_q;
  assign result_o.sample_voltage_mv   = out_v_q;
  assign result_o.sample_percent      = out_p_q;
  assign result_o.smoothed_voltage_mv = avg_v_q;
  assign result_o.smoothed_percent    = avg_p_q;

endmodule

`default_nettype wire
